// File: rtl/i2cms_pkg.sv
// package for the i2c master bit sequencer
// holds command codes, queue sizing and the word types shared between modules
package i2cms_pkg;

  // command codes, idle marks no command in progress
  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_STOP  = 3'd1,
    KIND_WRITE = 3'd2,
    KIND_READ  = 3'd3,
    KIND_CHECK = 3'd4,
    KIND_IDLE  = 3'd7
  } kind_e;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned PHASE_W     = 16;
  localparam logic [PHASE_W-1:0] PHASE_RESET = 16'd20;

  // apb register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // classified tick word passed from front to back
  typedef struct packed {
    logic       cmd_ok;
    kind_e      kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // result word for one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_seen;
  } res_t;

endpackage

// File: rtl/i2cms_ifs.sv
// valid/ready channel interfaces for the i2c master bit sequencer
// tick input channel and result output channel, no dependencies
interface i2cms_tick_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, kind, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, kind, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cms_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack_seen;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte, nack_seen,
                  input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte, nack_seen,
                  output ready);
endinterface

// File: rtl/i2c_master_bit_sequencer.sv
// top level of the i2c master bit sequencer: apb register, front, queue, back
// depends on i2cms_pkg, i2cms_ifs, i2cms_front, i2cms_queue, i2cms_back
//
// channel   dir  handshake      word
// tick_i    in   valid/ready    cmd_valid, kind, tx_byte, send_ack, sda_in
// res_o     out  valid/ready    scl_level, sda_level, busy_res, done_res, rx_byte, nack_seen
// apb       in   psel/penable   phase_ticks at byte address 0
//
// one tick word is taken per cycle while the queue has room, and gives one result word
// by way of the queue and then the result register; the sequencer step in the back end sets this rate
// the front and back are parted by a two-word queue, the back by its result register
// rst_ni clears the sequencer to idle with scl and sda released and phase_ticks at 20
// a stalled result holds the back; the front stalls only once the queue is full
module i2c_master_bit_sequencer import i2cms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  i2cms_tick_if.sink         tick_i,
  i2cms_res_if.source        res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [PHASE_W-1:0] phase_ticks_q;
  logic               reg_sel;
  logic               q_full, q_push, q_pop, q_valid;
  tick_t              front_entry, q_entry;

  // register file, phase_ticks at word 0
  assign reg_sel = !paddr[2];
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(PDATA_W-PHASE_W){1'b0}}, phase_ticks_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      phase_ticks_q <= pwdata[PHASE_W-1:0];
    end
  end

  // accept and classify
  i2cms_front u_front (
    .tick_i   (tick_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .entry_o  (front_entry)
  );

  // decoupling queue
  i2cms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // sequencer and result register
  i2cms_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .phase_ticks_i (phase_ticks_q),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .res_o         (res_o)
  );

endmodule

// File: rtl/i2cms_front.sv
// front end: accepts tick words and classifies the offered command
// depends on i2cms_pkg and i2cms_tick_if
module i2cms_front import i2cms_pkg::*; (
  i2cms_tick_if.sink tick_i,
  input  logic       q_full_i,
  output logic       push_o,
  output tick_t      entry_o
);

  // take a word whenever the queue has room
  assign tick_i.ready = !q_full_i;
  assign push_o       = tick_i.valid && !q_full_i;

  // a command counts only when offered with a known code
  always_comb begin
    entry_o.cmd_ok   = 1'b0;
    entry_o.kind     = KIND_START;
    entry_o.tx_byte  = tick_i.tx_byte;
    entry_o.send_ack = tick_i.send_ack;
    entry_o.sda_in   = tick_i.sda_in;
    case (tick_i.kind)
      KIND_START: begin entry_o.cmd_ok = tick_i.cmd_valid; entry_o.kind = KIND_START; end
      KIND_STOP:  begin entry_o.cmd_ok = tick_i.cmd_valid; entry_o.kind = KIND_STOP;  end
      KIND_WRITE: begin entry_o.cmd_ok = tick_i.cmd_valid; entry_o.kind = KIND_WRITE; end
      KIND_READ:  begin entry_o.cmd_ok = tick_i.cmd_valid; entry_o.kind = KIND_READ;  end
      KIND_CHECK: begin entry_o.cmd_ok = tick_i.cmd_valid; entry_o.kind = KIND_CHECK; end
      default: begin
        entry_o.cmd_ok = 1'b0;
        entry_o.kind   = KIND_START;
      end
    endcase
  end

endmodule

// File: rtl/i2cms_queue.sv
// short fifo of classified tick words between front and back
// depends on i2cms_pkg
module i2cms_queue import i2cms_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  tick_t entry_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output tick_t entry_o
);

  tick_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/i2cms_back.sv
// back end: pin sequencer state, phase timer and registered result word
// depends on i2cms_pkg and i2cms_res_if
module i2cms_back import i2cms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PHASE_W-1:0] phase_ticks_i,
  input  logic               q_valid_i,
  input  tick_t              q_entry_i,
  output logic               q_pop_o,
  i2cms_res_if.source        res_o
);

  kind_e              active_q, active_d;
  logic [4:0]         phase_q, phase_d;
  logic [PHASE_W-1:0] tick_q, tick_d;
  logic [7:0]         shift_q, shift_d;
  logic               ack_q, ack_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               nack_q, nack_d;
  logic [7:0]         rx_q, rx_d;
  logic               done;

  logic               out_valid_q;
  res_t               res_q;

  logic               step;
  logic               seg_en;
  logic [4:0]         seg_k;
  kind_e              seg_kind;
  logic [PHASE_W-1:0] limit;
  logic [PHASE_W:0]   tick_next;
  logic               finished;

  // k mod 3 for a 5 bit phase index, bit weights 1,2,1,2,1
  function automatic logic [1:0] mod3(input logic [4:0] k);
    logic [3:0] s;
    s = 4'(k[0]) + 4'(k[2]) + 4'(k[4]) + {2'b0, 1'b0, k[1]} * 4'd2 + {3'b0, k[3]} * 4'd2;
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9: mod3 = 2'd0;
      4'd1, 4'd4, 4'd7:       mod3 = 2'd1;
      4'd2, 4'd5, 4'd8:       mod3 = 2'd2;
      default:                mod3 = 2'd0;
    endcase
  endfunction

  // process one tick whenever the result register can take a word
  assign step      = q_valid_i && (!out_valid_q || res_o.ready);
  assign q_pop_o   = step;
  assign limit     = (phase_ticks_i == '0) ? PHASE_W'(1) : phase_ticks_i;
  assign tick_next = {1'b0, tick_q} + 1'b1;

  // next state of the sequencer
  always_comb begin
    active_d = active_q;
    phase_d  = phase_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    nack_d   = nack_q;
    rx_d     = rx_q;
    done     = 1'b0;
    seg_en   = 1'b0;
    seg_k    = '0;
    seg_kind = active_q;
    finished = 1'b0;

    // start a command or time the current phase
    if (active_q == KIND_IDLE) begin
      if (q_entry_i.cmd_ok) begin
        active_d = q_entry_i.kind;
        phase_d  = '0;
        tick_d   = '0;
        ack_d    = q_entry_i.send_ack;
        seg_en   = 1'b1;
        seg_kind = q_entry_i.kind;
        if (q_entry_i.kind == KIND_WRITE) begin
          shift_d = q_entry_i.tx_byte;
        end else if (q_entry_i.kind == KIND_READ) begin
          shift_d = '0;
        end
      end
    end else begin
      if (tick_next >= {1'b0, limit}) begin
        tick_d  = '0;
        phase_d = phase_q + 1'b1;
        seg_k   = phase_q + 1'b1;
        seg_en  = 1'b1;
      end else begin
        tick_d  = tick_next[PHASE_W-1:0];
      end
    end

    // pin actions of the segment that begins now
    if (seg_en) begin
      case (seg_kind)
        KIND_START: begin
          if (seg_k == 5'd0) begin
            scl_d = 1'b1;
            sda_d = 1'b1;
          end else if (seg_k == 5'd1) begin
            sda_d = 1'b0;
          end else if (seg_k == 5'd2) begin
            scl_d = 1'b0;
          end else begin
            finished = 1'b1;
          end
        end
        KIND_STOP: begin
          if (seg_k == 5'd0) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end else if (seg_k == 5'd1) begin
            sda_d = 1'b1;
          end else begin
            finished = 1'b1;
          end
        end
        KIND_CHECK: begin
          if (seg_k == 5'd0) begin
            sda_d = 1'b1;
          end else if (seg_k == 5'd1) begin
            scl_d = 1'b1;
          end else if (seg_k == 5'd2) begin
            nack_d = q_entry_i.sda_in;
            scl_d  = 1'b0;
          end else begin
            finished = 1'b1;
          end
        end
        KIND_WRITE: begin
          if (seg_k >= 5'd24) begin
            finished = 1'b1;
          end else begin
            case (mod3(seg_k))
              2'd0: begin
                if (seg_k == 5'd0) scl_d = 1'b0;
                sda_d = shift_d[7];
              end
              2'd1: begin
                scl_d = 1'b1;
              end
              default: begin
                scl_d = 1'b0;
                // sda released after the last bit
                if (seg_k == 5'd23) sda_d = 1'b1;
                shift_d = {shift_q[6:0], 1'b0};
              end
            endcase
          end
        end
        KIND_READ: begin
          if (seg_k < 5'd16) begin
            if (!seg_k[0]) begin
              scl_d = 1'b1;
            end else begin
              shift_d = {shift_q[6:0], q_entry_i.sda_in};
              scl_d   = 1'b0;
            end
          end else if (seg_k == 5'd16) begin
            rx_d  = shift_q;
            sda_d = !ack_q;
          end else if (seg_k == 5'd17) begin
            scl_d = 1'b1;
          end else if (seg_k == 5'd18) begin
            scl_d = 1'b0;
          end else begin
            if (ack_q) sda_d = 1'b1;
            finished = 1'b1;
          end
        end
        default: begin
          finished = 1'b1;
        end
      endcase
    end

    // command complete
    if (finished && (active_q != KIND_IDLE)) begin
      active_d = KIND_IDLE;
      phase_d  = '0;
      done     = 1'b1;
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= KIND_IDLE;
      phase_q  <= '0;
      tick_q   <= '0;
      shift_q  <= '0;
      ack_q    <= 1'b0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
      nack_q   <= 1'b0;
      rx_q     <= '0;
    end else if (step) begin
      active_q <= active_d;
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      shift_q  <= shift_d;
      ack_q    <= ack_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      nack_q   <= nack_d;
      rx_q     <= rx_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q.scl_level <= scl_d;
      res_q.sda_level <= sda_d;
      res_q.busy_res  <= (active_d != KIND_IDLE);
      res_q.done_res  <= done;
      res_q.rx_byte   <= rx_d;
      res_q.nack_seen <= nack_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.scl_level = res_q.scl_level;
  assign res_o.sda_level = res_q.sda_level;
  assign res_o.busy_res  = res_q.busy_res;
  assign res_o.done_res  = res_q.done_res;
  assign res_o.rx_byte   = res_q.rx_byte;
  assign res_o.nack_seen = res_q.nack_seen;

`ifndef SYNTHESIS
  // a finishing word never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.done_res |-> !res_q.busy_res)
    else $error("done reported while busy");

  // idle sequencer keeps its phase index cleared
  a_idle_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q == KIND_IDLE) |-> (phase_q == '0))
    else $error("phase index not cleared while idle");

  // idle sequencer keeps its phase timer cleared
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q == KIND_IDLE) |-> (tick_q == '0))
    else $error("phase timer not cleared while idle");
`endif

endmodule

// File: tb/sv/tb.sv
// self-checking bench for the i2c master bit sequencer: ticks in, pin words out
// depends on i2cms_pkg, i2cms_ifs and the i2c_master_bit_sequencer rtl
// an in-bench pin sequencer predicts every result word; apb sets phase_ticks per run
`timescale 1ns / 1ps

module tb;
  import i2cms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned REPORT_MAX  = 40;
  localparam int unsigned CMDS_PER_RUN = 5;
  localparam logic [PADDR_W-1:0] PHASE_ADDR = '0;

  // sda source for the ticks of one command
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  // one tick word as the sender offers it
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_word_t;

  logic clk_i;
  logic rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  i2cms_tick_if tick_if ();
  i2cms_res_if  res_if ();

  i2c_master_bit_sequencer uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tick_word_t ticks_to_send[$];
  res_t       pin_words_due[$];

  int unsigned miss_count = 0;
  int unsigned words_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  // sequencer shadow state
  logic [15:0] phase_cfg = PHASE_RESET;
  kind_e       cur_kind  = KIND_IDLE;
  logic [4:0]  seg_idx   = '0;
  logic [15:0] tick_cnt  = '0;
  logic [7:0]  shift_q   = '0;
  logic        ack_sel   = 1'b0;
  logic        scl_q     = 1'b1;
  logic        sda_q     = 1'b1;
  logic        nack_q    = 1'b0;
  logic [7:0]  rx_q      = '0;

  // clock, with every block input at a known level from time zero
  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_if.valid = 1'b0;
    tick_if.cmd_valid = 1'b0;
    tick_if.kind = '0;
    tick_if.tx_byte = '0;
    tick_if.send_ack = 1'b0;
    tick_if.sda_in = 1'b0;
    res_if.ready = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_miss(string what, logic [31:0] got, logic [31:0] want);
    miss_count++;
    if (miss_count <= REPORT_MAX) begin
      $display("mismatch: %s got %0h want %0h at result word %0d", what, got, want,
               words_checked);
    end
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_miss(name, got, want);
  endtask

  // pin actions of segment k of the running command, 1 when the command is over
  function automatic logic run_segment(logic [4:0] k, logic sda);
    logic fin;
    fin = 1'b0;
    case (cur_kind)
      KIND_START: begin
        if (k == 0) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
        end else if (k == 1) sda_q = 1'b0;
        else if (k == 2) scl_q = 1'b0;
        else fin = 1'b1;
      end
      KIND_STOP: begin
        if (k == 0) begin
          sda_q = 1'b0;
          scl_q = 1'b1;
        end else if (k == 1) sda_q = 1'b1;
        else fin = 1'b1;
      end
      KIND_CHECK: begin
        if (k == 0) sda_q = 1'b1;
        else if (k == 1) scl_q = 1'b1;
        else if (k == 2) begin
          nack_q = sda;
          scl_q = 1'b0;
        end else fin = 1'b1;
      end
      KIND_WRITE: begin
        // three segments per bit: data, clock high, clock low
        if (k >= 24) fin = 1'b1;
        else if (k % 3 == 0) begin
          if (k == 0) scl_q = 1'b0;
          sda_q = shift_q[7];
        end else if (k % 3 == 1) scl_q = 1'b1;
        else begin
          scl_q = 1'b0;
          if (k / 3 == 7) sda_q = 1'b1;
          shift_q = {shift_q[6:0], 1'b0};
        end
      end
      KIND_READ: begin
        // clock pulses sampling the byte msb first, then the ack bit
        if (k < 16) begin
          if (!k[0]) scl_q = 1'b1;
          else begin
            shift_q = {shift_q[6:0], sda};
            scl_q = 1'b0;
          end
        end else if (k == 16) begin
          rx_q = shift_q;
          sda_q = !ack_sel;
        end else if (k == 17) scl_q = 1'b1;
        else if (k == 18) scl_q = 1'b0;
        else begin
          if (ack_sel) sda_q = 1'b1;
          fin = 1'b1;
        end
      end
      default: fin = 1'b1;
    endcase
    return fin;
  endfunction

  // advance the shadow sequencer by one tick and give the pin word it leaves
  function automatic res_t pins_after_tick(tick_word_t w);
    res_t        r;
    logic [15:0] lim;
    logic [16:0] nxt;
    logic        fin;
    fin = 1'b0;
    lim = (phase_cfg == 0) ? 16'd1 : phase_cfg;
    if (cur_kind == KIND_IDLE) begin
      if (w.cmd_valid && w.kind <= KIND_CHECK) begin
        cur_kind = kind_e'(w.kind);
        seg_idx = '0;
        tick_cnt = '0;
        ack_sel = w.send_ack;
        if (w.kind == KIND_WRITE) shift_q = w.tx_byte;
        else if (w.kind == KIND_READ) shift_q = '0;
        void'(run_segment(5'd0, w.sda_in));
      end
    end else begin
      nxt = tick_cnt + 17'd1;
      if (nxt >= lim) begin
        tick_cnt = '0;
        seg_idx = seg_idx + 5'd1;
        if (run_segment(seg_idx, w.sda_in)) begin
          cur_kind = KIND_IDLE;
          seg_idx = '0;
          fin = 1'b1;
        end
      end else tick_cnt = nxt[15:0];
    end
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.busy_res  = (cur_kind != KIND_IDLE);
    r.done_res  = fin;
    r.rx_byte   = rx_q;
    r.nack_seen = nack_q;
    return r;
  endfunction

  // tick sender: holds a word until taken, predicts it on acceptance
  always @(posedge clk_i or negedge rst_ni) begin : tick_sender
    int unsigned calm;
    logic        gap;
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
      tick_if.cmd_valid <= 1'b0;
      tick_if.kind <= '0;
      tick_if.tx_byte <= '0;
      tick_if.send_ack <= 1'b0;
      tick_if.sda_in <= 1'b0;
      calm = 0;
    end else begin
      if (tick_if.valid && tick_if.ready) begin
        pin_words_due.push_back(pins_after_tick(ticks_to_send.pop_front()));
      end
      gap = 1'b0;
      if (calm != 0) calm--;
      else if ($urandom_range(0, 199) == 0) calm = $urandom_range(20, 80);
      else gap = ($urandom_range(0, 99) < gap_pct);
      if (!tick_if.valid || tick_if.ready) begin
        if (ticks_to_send.size() != 0 && !gap) begin
          tick_if.valid <= 1'b1;
          tick_if.cmd_valid <= ticks_to_send[0].cmd_valid;
          tick_if.kind <= ticks_to_send[0].kind;
          tick_if.tx_byte <= ticks_to_send[0].tx_byte;
          tick_if.send_ack <= ticks_to_send[0].send_ack;
          tick_if.sda_in <= ticks_to_send[0].sda_in;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: compares each taken word with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : pin_receiver
    int unsigned calm;
    logic        stall;
    res_t        want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      calm = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pin_words_due.size() == 0) begin
          report_miss("result word with none expected", 0, 0);
        end else begin
          want = pin_words_due.pop_front();
          check_field("scl_level", res_if.scl_level, want.scl_level);
          check_field("sda_level", res_if.sda_level, want.sda_level);
          check_field("busy_res", res_if.busy_res, want.busy_res);
          check_field("done_res", res_if.done_res, want.done_res);
          check_field("rx_byte", res_if.rx_byte, want.rx_byte);
          check_field("nack_seen", res_if.nack_seen, want.nack_seen);
        end
        words_checked++;
      end
      stall = 1'b0;
      if (calm != 0) calm--;
      else if ($urandom_range(0, 199) == 0) calm = $urandom_range(20, 80);
      else stall = ($urandom_range(0, 99) < stall_pct);
      res_if.ready <= !stall;
    end
  end

  // run length guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // number of delay phases a command spans
  function automatic int phases_of(logic [2:0] k);
    case (k)
      KIND_START: return 3;
      KIND_STOP:  return 2;
      KIND_WRITE: return 24;
      KIND_READ:  return 19;
      KIND_CHECK: return 3;
      default:    return 0;
    endcase
  endfunction

  function automatic logic pick_sda(int mode);
    if (mode == SDA_LOW) return 1'b0;
    if (mode == SDA_HIGH) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // command tick, ticks while it runs (noise offers are ignored), then quiet ticks
  task automatic queue_cmd(logic [2:0] k, logic [7:0] tx, logic ack, int sda_mode,
                           bit noise, int early, int quiet);
    tick_word_t w;
    int         n;
    n = phases_of(k) * ((phase_cfg == 0) ? 1 : int'(phase_cfg)) - early;
    if (n < 0) n = 0;
    w = '{cmd_valid: 1'b1, kind: k, tx_byte: tx, send_ack: ack, sda_in: pick_sda(sda_mode)};
    ticks_to_send.push_back(w);
    repeat (n) begin
      w.cmd_valid = noise ? 1'($urandom_range(0, 1)) : 1'b0;
      w.kind = 3'($urandom_range(0, 7));
      w.tx_byte = 8'($urandom);
      w.send_ack = 1'($urandom_range(0, 1));
      w.sda_in = pick_sda(sda_mode);
      ticks_to_send.push_back(w);
    end
    repeat (quiet) begin
      w.cmd_valid = 1'($urandom_range(0, 1));
      w.kind = 3'($urandom_range(KIND_CHECK + 1, KIND_IDLE));
      w.tx_byte = 8'($urandom);
      w.send_ack = 1'($urandom_range(0, 1));
      w.sda_in = 1'($urandom_range(0, 1));
      ticks_to_send.push_back(w);
    end
  endtask

  // one random command inside a transfer
  task automatic queue_rand_cmd(logic [2:0] k);
    int early;
    early = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    queue_cmd(k, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND, 1'b1, early,
              ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
  endtask

  // mostly well formed transfers: start, address, ack, data bytes, stop
  task automatic queue_transfers(int want);
    int made;
    made = 0;
    while (made < want) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_rand_cmd(3'($urandom_range(KIND_START, KIND_CHECK)));
        made++;
      end else begin
        queue_rand_cmd(KIND_START);
        queue_rand_cmd(KIND_WRITE);
        queue_rand_cmd(KIND_CHECK);
        made += 3;
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) begin
            queue_rand_cmd(KIND_WRITE);
            queue_rand_cmd(KIND_CHECK);
            made += 2;
          end else begin
            queue_rand_cmd(KIND_READ);
            made++;
          end
        end
        queue_rand_cmd(KIND_STOP);
        made++;
      end
    end
  endtask

  // wait until every tick is taken and every prediction met
  task automatic drain();
    while (ticks_to_send.size() != 0 || pin_words_due.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_phase_reg();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PHASE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[PHASE_W-1:0] !== phase_cfg) report_miss("phase_ticks readback",
                                                      prdata, phase_cfg);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // apb write of phase_ticks, only with the tick path drained
  task automatic set_phase(logic [15:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PHASE_ADDR;
    pwdata <= {{(PDATA_W-16){1'b0}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    phase_cfg = v;
    check_phase_reg();
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned gap_mode[4];
    int unsigned stall_mode[4];
    logic [15:0] run_phase[2];
    gap_mode = '{0, 61, 0, 33};
    stall_mode = '{0, 0, 61, 33};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_phase_reg();
    @(negedge clk_i);

    // reset phase length: start, ack check with sda low, stop
    queue_cmd(KIND_START, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 0);
    queue_cmd(KIND_CHECK, 8'h00, 1'b0, SDA_LOW, 1'b0, 0, 0);
    queue_cmd(KIND_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 2);
    drain();

    // shortest phase: read right after start keeps sda low, full byte out,
    // offers while busy, out of range kinds while idle, all-ones read with ack
    set_phase(16'd1);
    queue_cmd(KIND_START, 8'h5a, 1'b1, SDA_RAND, 1'b0, 0, 0);
    queue_cmd(KIND_READ, 8'h00, 1'b0, SDA_LOW, 1'b0, 0, 0);
    queue_cmd(KIND_WRITE, 8'hff, 1'b1, SDA_RAND, 1'b0, 0, 0);
    queue_cmd(KIND_WRITE, 8'ha5, 1'b0, SDA_RAND, 1'b1, 0, 6);
    queue_cmd(KIND_CHECK, 8'hff, 1'b1, SDA_HIGH, 1'b1, 0, 0);
    queue_cmd(KIND_READ, 8'hff, 1'b1, SDA_HIGH, 1'b0, 0, 0);
    queue_cmd(KIND_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 0);
    queue_cmd(KIND_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 0);
    drain();

    // zero phase length acts as one tick; one command lands while busy
    set_phase(16'd0);
    queue_cmd(KIND_START, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 0);
    queue_cmd(KIND_WRITE, 8'h80, 1'b0, SDA_RAND, 1'b0, 2, 0);
    queue_cmd(KIND_WRITE, 8'h01, 1'b0, SDA_RAND, 1'b0, 0, 0);
    queue_cmd(KIND_READ, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 0);
    queue_cmd(KIND_CHECK, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 0);
    queue_cmd(KIND_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 0);
    drain();

    // longer phase length, tick counter runs well past its low bits
    set_phase(16'd37);
    queue_cmd(KIND_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0, 0, 0);
    drain();

    // random transfers under each idling mode and two phase lengths
    for (int m = 0; m < 4; m++) begin
      gap_pct = gap_mode[m];
      stall_pct = stall_mode[m];
      run_phase = '{(m % 2 == 0) ? 16'd1 : 16'd0, 16'($urandom_range(2, 4))};
      for (int s = 0; s < 2; s++) begin
        set_phase(run_phase[s]);
        queue_transfers(CMDS_PER_RUN);
        drain();
      end
    end

    repeat (32) @(posedge clk_i);
    if (pin_words_due.size() != 0) report_miss("result words never seen",
                                               pin_words_due.size(), 0);
    if (miss_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
